>>> rtl/rcta_pkg.sv
package rcta_pkg;

    localparam int RCTA_COUNT_WIDTH = 16;

    localparam int RCTA_REG_W  = 16;
    localparam int RCTA_SUM_W  = 32;
    localparam int RCTA_AVG_W  = 24;
    localparam int RCTA_FRAC_W = 8;

    localparam int RCTA_DVD_W  = RCTA_SUM_W + RCTA_FRAC_W;
    localparam int RCTA_DVS_W  = RCTA_REG_W + 1;
    localparam int RCTA_STEP_W = $clog2(RCTA_DVD_W);

    localparam logic [RCTA_AVG_W-1:0] RCTA_AVG_MAX = 24'hFFFF00;

    localparam logic [RCTA_REG_W-1:0] RCTA_RST_SAMPLES   = 16'd10;
    localparam logic [RCTA_REG_W-1:0] RCTA_RST_TIMEOUT   = 16'd60000;
    localparam logic [RCTA_REG_W-1:0] RCTA_RST_DISCHARGE = 16'd1000;

endpackage

>>> rtl/rcta_div.sv
module rcta_div
    import rcta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RCTA_DVD_W-1:0] i_dividend,
    input  logic [RCTA_DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [RCTA_DVD_W-1:0] o_quotient
);

    logic                   r_busy;
    logic [RCTA_STEP_W-1:0] r_step;
    logic [RCTA_DVS_W-1:0]  r_rem;
    logic [RCTA_DVS_W-1:0]  r_dvs;
    logic [RCTA_DVD_W-1:0]  r_quo;

    logic [RCTA_DVS_W:0]    w_trial;
    logic [RCTA_DVS_W:0]    w_diff;
    logic                   w_qbit;

    // one restoring step per cycle, dividend shifts out as quotient shifts in
    assign w_trial = {r_rem, r_quo[RCTA_DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_qbit  = ~w_diff[RCTA_DVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= RCTA_STEP_W'(RCTA_DVD_W - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[RCTA_DVS_W-1:0] : w_trial[RCTA_DVS_W-1:0];
            r_quo <= {r_quo[RCTA_DVD_W-2:0], w_qbit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> rtl/rc_charge_time_averager_unit.sv
// channel  | dir | handshake              | payload
// s (tick) | in  | i_s_tvalid/o_s_tready  | i_s_tdata: start_req, sense_high
// m (res)  | out | o_m_tvalid/i_m_tready  | o_m_tdata: drives, busy, done, average_q8
// cfg      | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Back-to-back ticks are taken while the output register drains. The tick that
// ends a burst starts 40 serial restoring divider steps, one per cycle, over
// the 40-bit dividend; the quotient is then loaded into the result register
// once the output is free, and only after that is the next tick accepted.
// Synchronous active-low reset; no clearing pass. A stalled output holds the
// input side off until the result register is free.
module rc_charge_time_averager_unit
    import rcta_pkg::*;
#(
    parameter int COUNT_WIDTH = RCTA_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] start_req, [1] sense_high
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [0] discharge_drive, [1] charge_drive,
                                     // [2] busy_res, [3] done_res, [27:4] average_q8
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DISCHARGE = 2'd1;
    localparam logic [1:0] PH_CHARGE    = 2'd2;

    localparam logic SQ_RUN = 1'b0;
    localparam logic SQ_DIV = 1'b1;

    localparam logic [1:0] CFG_SAMPLES   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_DISCHARGE = 2'd2;

    logic [RCTA_REG_W-1:0]  r_sample_count;
    logic [RCTA_REG_W-1:0]  r_timeout;
    logic [RCTA_REG_W-1:0]  r_discharge;

    logic [1:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [RCTA_REG_W-1:0]  r_samples, n_samples;
    logic [RCTA_SUM_W-1:0]  r_sum, n_sum;
    logic [RCTA_AVG_W-1:0]  r_avg_hold;
    logic                   r_seq;

    logic                   r_out_valid;
    logic [3:0]             r_out_flags;
    logic [RCTA_AVG_W-1:0]  r_out_avg;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_start, w_sense;
    logic [32:0]            w_tick_ext;
    logic                   w_tick_max;
    logic                   w_finish;
    logic [RCTA_SUM_W-1:0]  w_value;
    logic [RCTA_REG_W-1:0]  w_samples_inc;
    logic                   w_burst_end;
    logic [3:0]             w_flags;
    logic                   w_div_busy;
    logic [RCTA_DVD_W-1:0]  w_quo;
    logic [RCTA_AVG_W-1:0]  w_avg_sat;
    logic                   w_div_load;

    assign w_start    = i_s_tdata[0];
    assign w_sense    = i_s_tdata[1];
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_seq == SQ_RUN) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign w_tick_ext    = 33'(r_tick);
    assign w_tick_max    = &r_tick;
    assign w_samples_inc = r_samples + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_samples   = r_samples;
        n_sum       = r_sum;
        w_finish    = 1'b0;
        w_value     = '0;
        w_burst_end = 1'b0;
        w_flags     = 4'b0000;
        unique case (r_phase)
            PH_DISCHARGE: begin
                w_flags = 4'b0101;
                if ((w_tick_ext + 33'd1 >= 33'(r_discharge)) || w_tick_max) begin
                    n_tick  = '0;
                    n_phase = PH_CHARGE;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            PH_CHARGE: begin
                w_flags = 4'b0110;
                if (w_sense) begin
                    w_finish = 1'b1;
                    w_value  = RCTA_SUM_W'(r_tick);
                end else if ((w_tick_ext > 33'(r_timeout)) || w_tick_max) begin
                    w_finish = 1'b1;
                    w_value  = RCTA_SUM_W'(r_timeout);
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_start) begin
                    n_sum     = '0;
                    n_samples = '0;
                    n_tick    = '0;
                    n_phase   = PH_DISCHARGE;
                end
            end
        endcase
        if (w_finish) begin
            n_sum     = r_sum + w_value;
            n_samples = w_samples_inc;
            n_tick    = '0;
            if ((w_samples_inc == '0) || (w_samples_inc >= r_sample_count)) begin
                w_burst_end = 1'b1;
                n_phase     = PH_IDLE;
            end else begin
                n_phase = PH_DISCHARGE;
            end
        end
    end

    rcta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_burst_end),
        .i_dividend ({n_sum, {RCTA_FRAC_W{1'b0}}}),
        .i_divisor  ({(w_samples_inc == '0), w_samples_inc}),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_avg_sat = ((w_quo[RCTA_DVD_W-1:RCTA_AVG_W] != '0) ||
                        (w_quo[RCTA_AVG_W-1:0] > RCTA_AVG_MAX))
                       ? RCTA_AVG_MAX : w_quo[RCTA_AVG_W-1:0];
    assign w_div_load = (r_seq == SQ_DIV) && !w_div_busy && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= RCTA_RST_SAMPLES;
            r_timeout      <= RCTA_RST_TIMEOUT;
            r_discharge    <= RCTA_RST_DISCHARGE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLES:   r_sample_count <= i_cfg_data;
                CFG_TIMEOUT:   r_timeout      <= i_cfg_data;
                CFG_DISCHARGE: r_discharge    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_samples <= '0;
            r_sum     <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_samples <= n_samples;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_RUN;
            r_out_valid <= 1'b0;
            r_avg_hold  <= '0;
        end else begin
            if (w_accept && w_burst_end) begin
                r_seq <= SQ_DIV;
            end else if (w_div_load) begin
                r_seq      <= SQ_RUN;
                r_avg_hold <= w_avg_sat;
            end
            if ((w_accept && !w_burst_end) || w_div_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_burst_end) begin
            r_out_flags <= w_flags;
            r_out_avg   <= r_avg_hold;
        end else if (w_div_load) begin
            r_out_flags <= 4'b1110;
            r_out_avg   <= w_avg_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_avg, r_out_flags};

endmodule

>>> rtl/rcta_chk.sv
module rcta_chk
    import rcta_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped under stall");

    a_done_in_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> o_m_tdata[2] && o_m_tdata[1] && !o_m_tdata[0])
        else $error("done outside a charge tick");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]) &&
                       (o_m_tdata[2] == (o_m_tdata[0] || o_m_tdata[1])))
        else $error("drive and busy flags inconsistent");

    a_avg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[27:4] <= RCTA_AVG_MAX)
        else $error("average above saturation limit");

endmodule

bind rc_charge_time_averager_unit rcta_chk u_rcta_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
